// ===== hdl/aging_key_set_macros.svh =====
// Assertion macros for the aging key set.
// Included by the top level; no other dependencies.
`ifndef AGING_KEY_SET_MACROS_SVH
`define AGING_KEY_SET_MACROS_SVH
// Assert that a property holds on every clock edge outside reset.
`define AKS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("aging_key_set: check failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define AKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aging_key_set: check failed");
`endif

// ===== hdl/aks_pkg.sv =====
// Shared types and constants for the aging key set.
// No dependencies.
package aks_pkg;
  localparam int unsigned Slots   = 64;
  localparam int unsigned Buckets = 256;
  localparam int unsigned SlotW   = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned BucketW = (Buckets > 1) ? $clog2(Buckets) : 1;

  localparam logic [1:0] FuncAdd    = 2'd0;
  localparam logic [1:0] FuncQuery  = 2'd1;
  localparam logic [1:0] FuncExpire = 2'd2;

  localparam logic AddrKeySize = 1'b0;
  localparam logic AddrTimeout = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key_hash;
    logic [63:0] key;
    logic [31:0] now;
  } aks_in_t;

  typedef struct packed {
    logic found;
    logic full_res;
  } aks_out_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWrite,
    StDone
  } aks_state_e;

  // Slot entry as held in memory.
  typedef struct packed {
    logic [63:0]        key;
    logic [BucketW-1:0] bucket;
    logic [31:0]        stamp;
  } aks_entry_t;

  // Memory write request from the sequencer.
  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] addr;
    aks_entry_t       data;
  } aks_wr_t;

  // Byte mask for key compare under the configured key size.
  function automatic logic [63:0] key_mask(input logic [3:0] ks, input logic [7:0] len);
    logic [3:0] nb;
    logic [63:0] m;
    if (ks == 4'd0) begin
      nb = (len > 8'd7) ? 4'd8 : (len[3:0] + 4'd1);
    end else begin
      nb = (ks > 4'd8) ? 4'd8 : ks;
    end
    for (int b = 0; b < 8; b++) begin
      m[b*8 +: 8] = (4'(b) < nb) ? 8'hff : 8'h00;
    end
    return m;
  endfunction
endpackage

// ===== hdl/aks_mem.sv =====
// Slot storage memory: one write port, one registered read port.
// Depends on aks_pkg.
module aks_mem (
  input  logic                     clk_i,
  input  aks_pkg::aks_wr_t         wr_i,
  input  logic [aks_pkg::SlotW-1:0] raddr_i,
  output aks_pkg::aks_entry_t      rdata_o
);
  import aks_pkg::*;

  aks_entry_t mem_q [Slots];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/aks_seq.sv =====
// Scan sequencer: walks all slots once per item through one compare unit.
// Depends on aks_pkg and drives the aks_mem ports.
module aks_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  aks_pkg::aks_in_t          item_i,
  input  logic [3:0]                key_size_i,
  input  logic [31:0]               timeout_i,
  output logic                      busy_o,
  output logic                      done_o,
  output aks_pkg::aks_out_t         result_o,
  output aks_pkg::aks_wr_t          wr_o,
  output logic [aks_pkg::SlotW-1:0] raddr_o,
  input  aks_pkg::aks_entry_t       rdata_i
);
  import aks_pkg::*;

  localparam int unsigned CntW = SlotW + 1;

  aks_state_e state_q, state_d;
  aks_in_t    item_q;
  logic [31:0] deadline_q;
  logic [Slots-1:0] valid_q;
  logic [CntW-1:0] rcnt_q, rcnt_d;   // next address to read
  logic [CntW-1:0] ccnt_q, ccnt_d;   // slot whose data is on rdata_i
  logic hit_q, hit_d;
  logic [SlotW-1:0] hit_idx_q, hit_idx_d;
  logic [63:0] hit_key_q, hit_key_d;  // stored key of the matching slot
  logic free_q, free_d;
  logic [SlotW-1:0] free_idx_q, free_idx_d;
  logic [BucketW-1:0] bucket;
  logic [SlotW-1:0] cidx;
  logic match, expire, cmp_live;
  logic [63:0] mask;

  assign bucket = item_q.key_hash[BucketW-1:0];
  assign cidx   = ccnt_q[SlotW-1:0];
  assign mask   = key_mask(key_size_i, item_q.key[7:0]);
  assign cmp_live = (state_q == StScan) && (ccnt_q < CntW'(Slots)) && (ccnt_q != rcnt_q);

  // Shared compare unit: one slot per cycle.
  always_comb begin
    match = valid_q[cidx] && (rdata_i.bucket == bucket) &&
            ((rdata_i.key & mask) == (item_q.key & mask)) &&
            !((key_size_i == 4'd0) && (rdata_i.key[7:0] != item_q.key[7:0]));
    expire = valid_q[cidx] && (rdata_i.stamp < deadline_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start_i) state_d = StScan;
      StScan:  if (ccnt_q == CntW'(Slots)) begin
                 state_d = (item_q.func == FuncAdd) ? StWrite : StDone;
               end
      StWrite: state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Scan counters and search results.
  always_comb begin
    rcnt_d = rcnt_q;
    ccnt_d = ccnt_q;
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    hit_key_d = hit_key_q;
    free_d = free_q;
    free_idx_d = free_idx_q;
    if (state_q == StIdle) begin
      rcnt_d = '0;
      ccnt_d = '0;
      hit_d = 1'b0;
      hit_idx_d = '0;
      hit_key_d = '0;
      free_d = 1'b0;
      free_idx_d = '0;
    end else if (state_q == StScan) begin
      if (rcnt_q < CntW'(Slots)) rcnt_d = rcnt_q + 1'b1;
      if (cmp_live) begin
        ccnt_d = ccnt_q + 1'b1;
        if (match && !hit_q) begin
          hit_d = 1'b1;
          hit_idx_d = cidx;
          hit_key_d = rdata_i.key;
        end
        if (!valid_q[cidx] && !free_q) begin
          free_d = 1'b1;
          free_idx_d = cidx;
        end
      end
    end
  end

  // Memory controls and outputs.
  always_comb begin
    raddr_o = rcnt_q[SlotW-1:0];
    wr_o.we = 1'b0;
    wr_o.addr = hit_q ? hit_idx_q : free_idx_q;
    wr_o.data.key = hit_q ? hit_key_q : item_q.key;
    wr_o.data.bucket = bucket;
    wr_o.data.stamp = item_q.now;
    busy_o = (state_q != StIdle);
    done_o = (state_q == StDone);
    result_o.found = 1'b0;
    result_o.full_res = 1'b0;
    if (state_q == StWrite) begin
      wr_o.we = hit_q || free_q;
    end
    if (state_q == StDone) begin
      result_o.found = hit_q && (item_q.func == FuncAdd || item_q.func == FuncQuery);
      result_o.full_res = (item_q.func == FuncAdd) && !hit_q && !free_q;
    end
  end

  // Registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      rcnt_q <= '0;
      ccnt_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rcnt_q <= rcnt_d;
      ccnt_q <= ccnt_d;
      hit_q <= hit_d;
      free_q <= free_d;
      if (state_q == StScan && cmp_live && item_q.func == FuncExpire && expire) begin
        valid_q[cidx] <= 1'b0;
      end
      if (state_q == StWrite && !hit_q && free_q) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    hit_key_q <= hit_key_d;
    free_idx_q <= free_idx_d;
    if (state_q == StIdle && start_i) begin
      item_q <= item_i;
      deadline_q <= (item_i.now >= timeout_i) ? (item_i.now - timeout_i) : 32'd0;
    end
  end
endmodule

// ===== hdl/aging_key_set.sv =====
// Aging key set: one item scans all 64 slots, one slot per cycle from memory.
// An item passes through a scan of all slots behind the registered read, a write step
// for add and a result step; a new item is accepted only once the block is back in idle,
// and the receiver cannot stall.
// Reset clears all slot valid flags at once and loads key_size 8, timeout 60.
// Depends on aks_pkg, aks_mem, aks_seq and aging_key_set_macros.svh.
`include "aging_key_set_macros.svh"
module aging_key_set (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  aks_pkg::aks_in_t   item_i,
  output logic               done_o,
  output aks_pkg::aks_out_t  result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:2]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import aks_pkg::*;

  logic [3:0]  key_size_q;
  logic [31:0] timeout_q;
  aks_wr_t     wr;
  logic [SlotW-1:0] raddr;
  aks_entry_t  rdata;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= 4'd8;
      timeout_q <= 32'd60;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        AddrKeySize: key_size_q <= pwdata[3:0];
        AddrTimeout: timeout_q <= pwdata;
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == AddrTimeout) ? timeout_q : {28'd0, key_size_q};

  aks_mem u_mem (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  aks_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .item_i    (item_i),
    .key_size_i(key_size_q),
    .timeout_i (timeout_q),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .result_o  (result_o),
    .wr_o      (wr),
    .raddr_o   (raddr),
    .rdata_i   (rdata)
  );

  // A result never reports both a hit and a dropped add.
  `AKS_ASSERT(a_res_excl, !(done_o && result_o.found && result_o.full_res))
  // An accepted item makes the block busy in the next cycle.
  `AKS_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  // The result strobe ends the item.
  `AKS_ASSERT_NEXT(a_done_idle, done_o, !busy_o)
endmodule
